>>> hw/rtl/srcp_pkg.sv
package srcp_pkg;

    // Table size default
    localparam int SRCP_ENTRY_COUNT = 4096;

    // Key and index reduction: the key is folded in STEP_BITS-wide digits
    localparam int KEY_W      = 64;
    localparam int STEP_BITS  = 4;
    localparam int STEP_COUNT = KEY_W / STEP_BITS;

    // Packed entry word layout
    localparam int PACK_W     = 64;
    localparam int MOVE_LSB   = 0;
    localparam int MOVE_W     = 24;
    localparam int SCORE_LSB  = 24;
    localparam int SCORE_W    = 16;
    localparam int DEPTH_LSB  = 40;
    localparam int DEPTH_W    = 8;
    localparam int KIND_LSB   = 48;
    localparam int KIND_W     = 2;
    localparam int CHECK_LSB  = 50;
    localparam int CHECK_W    = 14;

    // Function codes
    localparam logic FUNC_PROBE = 1'b0;
    localparam logic FUNC_STORE = 1'b1;

    // Bound kinds
    localparam logic [KIND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [KIND_W-1:0] BOUND_UPPER = 2'd1;
    localparam logic [KIND_W-1:0] BOUND_LOWER = 2'd2;

    localparam logic signed [SCORE_W-1:0] MISS_SCORE = -16'sd32000;

    typedef struct packed {
        logic                        func;
        logic [KEY_W-1:0]            position_key;
        logic signed [SCORE_W-1:0]   lower_window;
        logic signed [SCORE_W-1:0]   upper_window;
        logic [DEPTH_W-1:0]          search_depth;
        logic signed [SCORE_W-1:0]   new_score;
        logic [KIND_W-1:0]           bound_kind;
        logic [MOVE_W-1:0]           new_move;
    } t_in_item;

    typedef struct packed {
        logic signed [SCORE_W-1:0]   probe_score;
        logic                        usable_hit;
        logic                        move_found;
        logic [MOVE_W-1:0]           found_move;
    } t_out_item;

    // Build the stored word for a store transaction
    function automatic logic [PACK_W-1:0] pack_entry(input t_in_item item);
        logic [PACK_W-1:0] w;
        w = '0;
        w[MOVE_LSB  +: MOVE_W]  = item.new_move;
        w[SCORE_LSB +: SCORE_W] = item.new_score;
        w[DEPTH_LSB +: DEPTH_W] = item.search_depth;
        w[KIND_LSB  +: KIND_W]  = item.bound_kind;
        w[CHECK_LSB +: CHECK_W] = item.position_key[CHECK_LSB +: CHECK_W];
        return w;
    endfunction

endpackage

>>> hw/rtl/srcp_slot.sv
module srcp_slot
    import srcp_pkg::*;
#(
    parameter int ENTRY_COUNT = SRCP_ENTRY_COUNT,
    parameter int IDX_W       = $clog2(ENTRY_COUNT)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [KEY_W-1:0]  i_key,
    output logic              o_done,
    output logic [IDX_W-1:0]  o_slot
);

    localparam bit IS_POW2 = (ENTRY_COUNT & (ENTRY_COUNT - 1)) == 0;

    generate
        if (IS_POW2) begin : g_pow2
            logic             r_done;
            logic [IDX_W-1:0] r_slot;

            // Power-of-two size: slot is the low key bits
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_slot <= i_key[IDX_W-1:0];
                end
            end

            assign o_done = r_done;
            assign o_slot = r_slot;
        end else begin : g_mod
            // Folded sum stays below ENTRY_COUNT << RED_STEPS
            localparam int RED_STEPS  = STEP_BITS + $clog2(STEP_COUNT);
            localparam int HALF_STEPS = RED_STEPS / 2;
            localparam int SUM_W      = IDX_W + RED_STEPS;
            localparam logic [IDX_W:0]   N_EXT = (IDX_W + 1)'(ENTRY_COUNT);
            localparam logic [SUM_W-1:0] N_SUM = SUM_W'(ENTRY_COUNT);

            // 2**sh modulo the table size, by doubling and subtracting
            function automatic logic [IDX_W-1:0] pow2_mod(input int sh);
                logic [IDX_W:0] r;
                r = (IDX_W + 1)'(1);
                for (int k = 0; k < sh; k++) begin
                    r = r << 1;
                    if (r >= N_EXT) begin
                        r = r - N_EXT;
                    end
                end
                return r[IDX_W-1:0];
            endfunction

            logic             r_busy;
            logic             r_done;
            logic             r_phase;
            logic [SUM_W-1:0] r_sum;
            logic [SUM_W-1:0] n_sum;
            logic [SUM_W-1:0] fold_sum;
            logic [SUM_W-1:0] sub_val;
            logic [SUM_W-1:0] part [STEP_COUNT];

            // Each key digit times its constant residue
            for (genvar g = 0; g < STEP_COUNT; g++) begin : g_part
                localparam logic [IDX_W-1:0] RES = pow2_mod(STEP_BITS * g);
                assign part[g] = SUM_W'(i_key[STEP_BITS*g +: STEP_BITS]) * SUM_W'(RES);
            end

            always_comb begin
                fold_sum = '0;
                for (int i = 0; i < STEP_COUNT; i++) begin
                    fold_sum = fold_sum + part[i];
                end
            end

            // Compare and subtract, upper half of the shifts first, then lower
            always_comb begin
                n_sum   = r_sum;
                sub_val = '0;
                for (int j = HALF_STEPS - 1; j >= 0; j--) begin
                    sub_val = N_SUM << (r_phase ? j : j + HALF_STEPS);
                    if (n_sum >= sub_val) begin
                        n_sum = n_sum - sub_val;
                    end
                end
            end

            // Fold at start, then an upper and a lower reduce phase; the done flag rises with the lower phase's result
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b0;
                    r_phase <= 1'b0;
                end else begin
                    r_done <= r_busy && r_phase;
                    if (i_start) begin
                        r_busy  <= 1'b1;
                        r_phase <= 1'b0;
                    end else if (r_busy) begin
                        r_phase <= !r_phase;
                        if (r_phase) begin
                            r_busy <= 1'b0;
                        end
                    end
                end
                if (i_start) begin
                    r_sum <= fold_sum;
                end else if (r_busy) begin
                    r_sum <= n_sum;
                end
            end

            assign o_done = r_done;
            assign o_slot = r_sum[IDX_W-1:0];
        end
    endgenerate

endmodule

>>> hw/rtl/srcp_table.sv
module srcp_table
    import srcp_pkg::*;
#(
    parameter int ENTRY_COUNT = SRCP_ENTRY_COUNT,
    parameter int IDX_W       = $clog2(ENTRY_COUNT)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_we,
    input  logic               i_re,
    input  logic [IDX_W-1:0]   i_addr,
    input  logic [KEY_W-1:0]   i_wkey,
    input  logic [PACK_W-1:0]  i_wpack,
    output logic [KEY_W-1:0]   o_rkey,
    output logic [PACK_W-1:0]  o_rpack,
    output logic               o_clr_busy
);

    logic [KEY_W-1:0]  key_mem  [ENTRY_COUNT];
    logic [PACK_W-1:0] pack_mem [ENTRY_COUNT];

    logic              r_clr_busy;
    logic [IDX_W-1:0]  r_clr_idx;
    logic [KEY_W-1:0]  r_rkey;
    logic [PACK_W-1:0] r_rpack;

    logic              we_m;
    logic [IDX_W-1:0]  waddr_m;
    logic [KEY_W-1:0]  wkey_m;
    logic [PACK_W-1:0] wpack_m;

    // Clearing pass after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == IDX_W'(ENTRY_COUNT - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Write port: clear sweep wins, user writes only come after it
    always_comb begin
        if (r_clr_busy) begin
            we_m    = 1'b1;
            waddr_m = r_clr_idx;
            wkey_m  = '0;
            wpack_m = '0;
        end else begin
            we_m    = i_we;
            waddr_m = i_addr;
            wkey_m  = i_wkey;
            wpack_m = i_wpack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_m) begin
            key_mem[waddr_m]  <= wkey_m;
            pack_mem[waddr_m] <= wpack_m;
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rkey  <= key_mem[i_addr];
            r_rpack <= pack_mem[i_addr];
        end
    end

    assign o_rkey     = r_rkey;
    assign o_rpack    = r_rpack;
    assign o_clr_busy = r_clr_busy;

endmodule

>>> hw/rtl/srcp_eval.sv
module srcp_eval
    import srcp_pkg::*;
(
    input  t_in_item           i_req,
    input  logic [KEY_W-1:0]   i_st_key,
    input  logic [PACK_W-1:0]  i_st_pack,
    output t_out_item          o_res
);

    logic                      match;
    logic signed [SCORE_W-1:0] st_score;
    logic [DEPTH_W-1:0]        st_depth;
    logic [KIND_W-1:0]         st_kind;

    assign st_score = $signed(i_st_pack[SCORE_LSB +: SCORE_W]);
    assign st_depth = i_st_pack[DEPTH_LSB +: DEPTH_W];
    assign st_kind  = i_st_pack[KIND_LSB +: KIND_W];

    // Full key and check must both agree
    assign match = (i_st_key == i_req.position_key) &&
                   (i_st_pack[CHECK_LSB +: CHECK_W] ==
                    i_req.position_key[CHECK_LSB +: CHECK_W]);

    // Score selection by bound kind when stored depth is deep enough; the move is returned on any match
    always_comb begin
        o_res.probe_score = MISS_SCORE;
        o_res.usable_hit  = 1'b0;
        o_res.move_found  = match;
        o_res.found_move  = '0;
        if (match) begin
            o_res.found_move = i_st_pack[MOVE_LSB +: MOVE_W];
            if (st_depth >= i_req.search_depth) begin
                case (st_kind)
                    BOUND_EXACT: begin
                        o_res.probe_score = st_score;
                        o_res.usable_hit  = 1'b1;
                    end
                    BOUND_UPPER: begin
                        if (st_score <= i_req.lower_window) begin
                            o_res.probe_score = i_req.lower_window;
                            o_res.usable_hit  = 1'b1;
                        end
                    end
                    BOUND_LOWER: begin
                        if (st_score >= i_req.upper_window) begin
                            o_res.probe_score = i_req.upper_window;
                            o_res.usable_hit  = 1'b1;
                        end
                    end
                    default: begin
                        // kind three never yields a usable score
                    end
                endcase
            end
        end
    end

endmodule

>>> hw/rtl/search_result_cache_probe.sv
// Channel   Direction  Payload      Handshake
// in        input      t_in_item    i_in_valid / o_in_stall
// out       output     t_out_item   o_out_valid / i_out_stall
//
// One transaction at a time. A power-of-two ENTRY_COUNT takes the slot from the low
// key bits; otherwise the slot unit folds the key digits with constant residues and
// finishes with compare and subtract.
// A store then writes the table in the access state; a probe reads it there and
// waits in the result state until the output register is free.
// After reset a clearing pass writes zeros to every entry, and o_in_stall stays
// high until it ends. A waiting result holds the last state until taken;
// the next transaction may be accepted while a result sits in the output register.
module search_result_cache_probe
    import srcp_pkg::*;
#(
    parameter int ENTRY_COUNT = SRCP_ENTRY_COUNT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int IDX_W = $clog2(ENTRY_COUNT);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_INDEX,
        S_ACCESS,
        S_RESULT
    } t_state;

    t_state            r_state;
    t_in_item          r_item;
    logic [IDX_W-1:0]  r_slot;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic              in_acc;
    logic              idx_done;
    logic [IDX_W-1:0]  idx_slot;
    logic              tbl_we;
    logic              tbl_re;
    logic [KEY_W-1:0]  tbl_rkey;
    logic [PACK_W-1:0] tbl_rpack;
    logic              clr_busy;
    logic              out_free;
    logic              n_out_valid;
    t_out_item         eval_res;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Output register: load a new result or keep a stalled one
    assign n_out_valid = ((r_state == S_RESULT) && out_free) ? 1'b1
                                                             : (r_out_valid && i_out_stall);

    // Key to slot reduction
    srcp_slot #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .IDX_W       (IDX_W)
    ) u_slot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_key   (i_in_data.position_key),
        .o_done  (idx_done),
        .o_slot  (idx_slot)
    );

    // Table access, in the cycle after the slot is known
    assign tbl_we = (r_state == S_ACCESS) && (r_item.func == FUNC_STORE);
    assign tbl_re = (r_state == S_ACCESS) && (r_item.func == FUNC_PROBE);

    srcp_table #(
        .ENTRY_COUNT (ENTRY_COUNT),
        .IDX_W       (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (tbl_we),
        .i_re       (tbl_re),
        .i_addr     (r_slot),
        .i_wkey     (r_item.position_key),
        .i_wpack    (pack_entry(r_item)),
        .o_rkey     (tbl_rkey),
        .o_rpack    (tbl_rpack),
        .o_clr_busy (clr_busy)
    );

    srcp_eval u_eval (
        .i_req     (r_item),
        .i_st_key  (tbl_rkey),
        .i_st_pack (tbl_rpack),
        .o_res     (eval_res)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                S_CLEAR: begin
                    if (!clr_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_INDEX;
                    end
                end
                S_INDEX: begin
                    if (idx_done) begin
                        r_state <= S_ACCESS;
                    end
                end
                S_ACCESS: begin
                    r_state <= (r_item.func == FUNC_STORE) ? S_IDLE : S_RESULT;
                end
                S_RESULT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (in_acc) begin
            r_item <= i_in_data;
        end
        if (r_state == S_INDEX && idx_done) begin
            r_slot <= idx_slot;
        end
        if (r_state == S_RESULT && out_free) begin
            r_out_data <= eval_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks
    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(tbl_we && tbl_re))
        else $error("table read and write in one cycle");

    a_done_in_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        idx_done |-> (r_state == S_INDEX))
        else $error("slot unit finished outside the index state");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        idx_done |-> (32'(idx_slot) < 32'(ENTRY_COUNT)))
        else $error("slot beyond table size");

    a_stall_while_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> o_in_stall)
        else $error("input open during clearing pass");

endmodule

>>> dv/search_result_cache_probe_tb.sv
`timescale 1ns / 100ps

module search_result_cache_probe_tb;
    import srcp_pkg::*;

    localparam int TABLE_SLOTS    = SRCP_ENTRY_COUNT;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int DRAIN_CYCLES   = 32;
    localparam int WATCHDOG_LIMIT = TABLE_SLOTS * 4 + 2000;
    localparam int HOT_SLOTS      = 8;
    localparam int KEY_POOL_SIZE  = 40;

    // Kind value the block accepts but never treats as a usable bound
    localparam logic [KIND_W-1:0] BOUND_RESERVED = 2'd3;

    // Directed keys
    localparam logic [KEY_W-1:0] KEY_ZERO    = 64'h0;
    localparam logic [KEY_W-1:0] KEY_ALIAS0  = 64'h0000_0000_0000_1000;
    localparam logic [KEY_W-1:0] KEY_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_COLLIDE = 64'h0004_0000_0000_0FFF;
    localparam logic [KEY_W-1:0] KEY_LOWER   = 64'hABCD_0000_1234_5123;
    localparam logic [KEY_W-1:0] KEY_RESV    = 64'h5555_AAAA_5555_A777;
    localparam logic [KEY_W-1:0] KEY_MISSVAL = 64'h0123_4567_89AB_C3C3;
    localparam logic [KEY_W-1:0] KEY_SLOT0   = 64'hFFFC_0000_0000_0000;

    // Mirror of one table slot
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [CHECK_W-1:0]        check;
        logic [KIND_W-1:0]         kind;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
    } t_slot_entry;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_directed_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    t_slot_entry   slot_table [TABLE_SLOTS];
    t_out_item     pending_probe_results [$];
    t_directed_row directed_rows [$];
    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    int  sink_cycle = 0;
    bit  sender_quiet = 1'b0;

    search_result_cache_probe u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic int unsigned slot_of(logic [KEY_W-1:0] key);
        return int'(key % 64'(TABLE_SLOTS));
    endfunction

    // Apply one transaction to the mirror table; returns 1 when a probe result is due
    function automatic bit predict_probe_result(input t_in_item it, output t_out_item res);
        int unsigned idx;
        t_slot_entry e;
        idx = slot_of(it.position_key);
        res.probe_score = MISS_SCORE;
        res.usable_hit  = 1'b0;
        res.move_found  = 1'b0;
        res.found_move  = '0;
        if (it.func == FUNC_STORE) begin
            e.key   = it.position_key;
            e.check = it.position_key[CHECK_LSB +: CHECK_W];
            e.kind  = it.bound_kind;
            e.depth = it.search_depth;
            e.score = it.new_score;
            e.move  = it.new_move;
            slot_table[idx] = e;
            return 1'b0;
        end
        e = slot_table[idx];
        if (e.key == it.position_key && e.check == it.position_key[CHECK_LSB +: CHECK_W]) begin
            res.move_found = 1'b1;
            res.found_move = e.move;
            if (e.depth >= it.search_depth) begin
                case (e.kind)
                    BOUND_EXACT: begin
                        res.probe_score = e.score;
                        res.usable_hit  = 1'b1;
                    end
                    BOUND_UPPER: begin
                        if (e.score <= it.lower_window) begin
                            res.probe_score = it.lower_window;
                            res.usable_hit  = 1'b1;
                        end
                    end
                    BOUND_LOWER: begin
                        if (e.score >= it.upper_window) begin
                            res.probe_score = it.upper_window;
                            res.usable_hit  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
        return 1'b1;
    endfunction

    // Unused fields of each transaction carry random values
    function automatic t_in_item store_item(logic [KEY_W-1:0] key, logic signed [SCORE_W-1:0] score,
                                            logic [DEPTH_W-1:0] depth, logic [KIND_W-1:0] kind,
                                            logic [MOVE_W-1:0] move);
        t_in_item it;
        it.func         = FUNC_STORE;
        it.position_key = key;
        it.lower_window = SCORE_W'($urandom);
        it.upper_window = SCORE_W'($urandom);
        it.search_depth = depth;
        it.new_score    = score;
        it.bound_kind   = kind;
        it.new_move     = move;
        return it;
    endfunction

    function automatic t_in_item probe_item(logic [KEY_W-1:0] key, logic signed [SCORE_W-1:0] alpha,
                                            logic signed [SCORE_W-1:0] beta,
                                            logic [DEPTH_W-1:0] depth);
        t_in_item it;
        it.func         = FUNC_PROBE;
        it.position_key = key;
        it.lower_window = alpha;
        it.upper_window = beta;
        it.search_depth = depth;
        it.new_score    = SCORE_W'($urandom);
        it.bound_kind   = KIND_W'($urandom);
        it.new_move     = MOVE_W'($urandom);
        return it;
    endfunction

    // Window value near a stored score, or anywhere in range
    function automatic logic signed [SCORE_W-1:0] near_score(logic signed [SCORE_W-1:0] s);
        if ($urandom_range(99) < 50) return s + SCORE_W'($urandom_range(4)) - SCORE_W'(2);
        return SCORE_W'($urandom);
    endfunction

    // Drive one transaction, wait for acceptance, record what it should return
    task automatic issue(input t_in_item it, input bit typed, input t_out_item want);
        int gap;
        bit gives;
        t_out_item predicted;
        gap = sender_quiet ? 0 : pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        gives = predict_probe_result(it, predicted);
        if (gives) pending_probe_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // Result side stall: random runs, with quiet stretches
    always @(negedge i_clk) begin
        sink_cycle <= sink_cycle + 1;
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left  <= ((sink_cycle % 2000) < 400) ? 0 : pick_gap();
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_probe_results.size() == 0) begin
                $error("unexpected result transaction: score %0d hit %0b found %0b move %h",
                       o_out_data.probe_score, o_out_data.usable_hit,
                       o_out_data.move_found, o_out_data.found_move);
                mismatch_count++;
            end else begin
                want = pending_probe_results.pop_front();
                if (o_out_data.probe_score !== want.probe_score) begin
                    $error("probe_score: expected %0d, got %0d",
                           want.probe_score, o_out_data.probe_score);
                    mismatch_count++;
                end
                if (o_out_data.usable_hit !== want.usable_hit) begin
                    $error("usable_hit: expected %0b, got %0b",
                           want.usable_hit, o_out_data.usable_hit);
                    mismatch_count++;
                end
                if (o_out_data.move_found !== want.move_found) begin
                    $error("move_found: expected %0b, got %0b",
                           want.move_found, o_out_data.move_found);
                    mismatch_count++;
                end
                if (o_out_data.found_move !== want.found_move) begin
                    $error("found_move: expected %h, got %h",
                           want.found_move, o_out_data.found_move);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_out_item   none;
        t_in_item    it;
        t_slot_entry e;
        logic [KEY_W-1:0] hot [HOT_SLOTS];
        logic [KEY_W-1:0] k;
        int unsigned r;

        none = '0;
        foreach (slot_table[i]) slot_table[i] = '0;

        // Directed table: typed expectations where obvious, predictor elsewhere
        // cleared slot 0 matches key zero
        directed_rows.push_back('{probe_item(KEY_ZERO, 16'sh0, 16'sh0, 8'd0), 1'b1,
                                  '{16'sh0, 1'b1, 1'b1, 24'h0}});
        // same slot, different key
        directed_rows.push_back('{probe_item(KEY_ALIAS0, 16'sh0, 16'sh0, 8'd0), 1'b1,
                                  '{MISS_SCORE, 1'b0, 1'b0, 24'h0}});
        // cleared entry too shallow
        directed_rows.push_back('{probe_item(KEY_ZERO, 16'sh0, 16'sh0, 8'd1), 1'b1,
                                  '{MISS_SCORE, 1'b0, 1'b1, 24'h0}});
        // top extremes, probe right behind the store
        directed_rows.push_back('{store_item(KEY_ONES, 16'sh7FFF, 8'hFF, BOUND_EXACT, 24'hFFFFFF),
                                  1'b0, none});
        directed_rows.push_back('{probe_item(KEY_ONES, 16'sh0, 16'sh0, 8'hFF), 1'b1,
                                  '{16'sh7FFF, 1'b1, 1'b1, 24'hFFFFFF}});
        // overwrite the same slot with another key and check bits
        directed_rows.push_back('{store_item(KEY_COLLIDE, 16'sh8000, 8'd0, BOUND_UPPER, 24'h0),
                                  1'b0, none});
        directed_rows.push_back('{probe_item(KEY_ONES, 16'sh0, 16'sh0, 8'd0), 1'b1,
                                  '{MISS_SCORE, 1'b0, 1'b0, 24'h0}});
        directed_rows.push_back('{probe_item(KEY_COLLIDE, 16'sh8000, 16'sh0, 8'd0), 1'b1,
                                  '{16'sh8000, 1'b1, 1'b1, 24'h0}});
        directed_rows.push_back('{probe_item(KEY_COLLIDE, 16'sh7FFF, 16'sh0, 8'd0), 1'b0, none});
        // lower bound at, above and below beta; depth just too shallow
        directed_rows.push_back('{store_item(KEY_LOWER, 16'sd100, 8'd10, BOUND_LOWER, 24'd123456),
                                  1'b0, none});
        directed_rows.push_back('{probe_item(KEY_LOWER, 16'sh0, 16'sd100, 8'd10), 1'b0, none});
        directed_rows.push_back('{probe_item(KEY_LOWER, 16'sh0, 16'sd101, 8'd10), 1'b0, none});
        directed_rows.push_back('{probe_item(KEY_LOWER, 16'sh0, 16'sd50, 8'd11), 1'b0, none});
        directed_rows.push_back('{probe_item(KEY_LOWER, 16'sh7FFF, 16'sh8000, 8'd0), 1'b1,
                                  '{16'sh8000, 1'b1, 1'b1, 24'd123456}});
        // bound kind three: move only
        directed_rows.push_back('{store_item(KEY_RESV, 16'sh0, 8'hFF, BOUND_RESERVED, 24'hA5A5A5),
                                  1'b0, none});
        directed_rows.push_back('{probe_item(KEY_RESV, 16'sh7FFF, 16'sh8000, 8'd0), 1'b1,
                                  '{MISS_SCORE, 1'b0, 1'b1, 24'hA5A5A5}});
        // a cached score equal to the miss value is still a hit
        directed_rows.push_back('{store_item(KEY_MISSVAL, MISS_SCORE, 8'd5, BOUND_EXACT, 24'd1),
                                  1'b0, none});
        directed_rows.push_back('{probe_item(KEY_MISSVAL, 16'sh0, 16'sh0, 8'd5), 1'b1,
                                  '{MISS_SCORE, 1'b1, 1'b1, 24'd1}});
        // upper bound stored too shallow for the probe depth gives no score
        directed_rows.push_back('{probe_item(KEY_COLLIDE, 16'sh8000, 16'sh0, 8'd1), 1'b1,
                                  '{MISS_SCORE, 1'b0, 1'b1, 24'h0}});
        // replace the cleared entry in slot 0
        directed_rows.push_back('{store_item(KEY_SLOT0, 16'sh1234, 8'd7, BOUND_UPPER, 24'h00FF00),
                                  1'b0, none});
        directed_rows.push_back('{probe_item(KEY_ZERO, 16'sh0, 16'sh0, 8'd0), 1'b1,
                                  '{MISS_SCORE, 1'b0, 1'b0, 24'h0}});
        directed_rows.push_back('{probe_item(KEY_SLOT0, 16'sh1234, 16'sh0, 8'd7), 1'b0, none});

        // Key pool: a few hot slots, plus keys that differ only in the check bits
        hot[0] = 64'(0);
        hot[1] = 64'(TABLE_SLOTS - 1);
        for (int i = 2; i < HOT_SLOTS; i++) hot[i] = 64'($urandom_range(TABLE_SLOTS - 1));
        for (int i = 0; i < KEY_POOL_SIZE; i++) begin
            k = {$urandom, $urandom};
            r = $urandom_range(99);
            if (i > 0 && r < 25) begin
                k = key_pool[$urandom_range(i - 1)];
                k[CHECK_LSB +: CHECK_W] = k[CHECK_LSB +: CHECK_W] ^ CHECK_W'($urandom_range(1 << CHECK_W - 1, 1));
            end else if (r < 85) begin
                k = k - (k % 64'(TABLE_SLOTS)) + hot[$urandom_range(HOT_SLOTS - 1)];
            end
            key_pool[i] = k;
        end

        // Reset, then wait out the clearing pass through the stall
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) issue(directed_rows[i].item, directed_rows[i].typed,
                                         directed_rows[i].want);

        // Hold off until the table is quiet
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_probe_results.size() != 0) @(negedge i_clk);

        // Random part: stores and probes over the key pool, some stray keys
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sender_quiet = (n % 300) < 80;
            if (n == RANDOM_ITEMS / 2) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
                while (pending_probe_results.size() != 0) @(negedge i_clk);
            end
            r = $urandom_range(99);
            k = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
            if (r < 35) begin
                it = store_item(k,
                                ($urandom_range(1)) ? SCORE_W'($urandom)
                                                    : SCORE_W'($urandom_range(400)) - SCORE_W'(200),
                                ($urandom_range(99) < 70) ? DEPTH_W'($urandom_range(12))
                                                          : DEPTH_W'($urandom),
                                KIND_W'($urandom),
                                MOVE_W'($urandom));
            end else if (r < 95) begin
                e  = slot_table[slot_of(k)];
                it = probe_item(k, near_score(e.score), near_score(e.score),
                                ($urandom_range(99) < 70) ? DEPTH_W'($urandom_range(12))
                                                          : DEPTH_W'($urandom));
            end else begin
                it = probe_item({$urandom, $urandom}, SCORE_W'($urandom), SCORE_W'($urandom),
                                DEPTH_W'($urandom));
            end
            issue(it, 1'b0, none);
        end
        i_in_valid <= 1'b0;

        // Drain, then keep watching for stray results
        while (pending_probe_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_probe_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
